/* design/ntpod_pkg.sv */
// Shared types and constants for the NTP reply offset and delay core.
`timescale 1ns / 1ps
package ntpod_pkg;

	localparam logic [3:0]  HEADER_WORD   = 4'd0;
	localparam logic [3:0]  FIRST_STAMP   = 4'd6;
	localparam logic [3:0]  LAST_WORD     = 4'd11;
	localparam logic [3:0]  IDLE_COUNT    = 4'd12;
	localparam int          NUM_STAMPS    = 6;
	localparam int          QUEUE_DEPTH   = 2;

	localparam logic signed [16:0] ZONE_RESET = 17'sd28800;
	localparam logic [31:0] EPOCH_1900_TO_1970 = 32'h83aa7e80;
	localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
	localparam logic [31:0] SETU_ROUND    = 32'd32768;
	localparam logic [9:0]  SETU_SCALE    = 10'd759;
	localparam logic signed [52:0] RT_MAX = 53'sd2147483647;
	localparam logic signed [52:0] RT_MIN = -53'sd2147483648;

	// One complete reply, handed from the word collector to the arithmetic.
	typedef struct packed {
		logic [31:0]        header;
		logic [63:0]        originate;
		logic [63:0]        receive;
		logic [63:0]        transmit;
		logic [63:0]        arrival;
		logic signed [16:0] zone;
	} job_t;

endpackage

/* design/ntpod_if.sv */
// Channel interfaces: reply words in, results out, and the configuration write.
`timescale 1ns / 1ps
interface ntpod_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] packet_word;
	logic        start_of_packet;
	logic [31:0] arrival_seconds;
	logic [31:0] arrival_fraction;

	modport source (output valid, output packet_word, output start_of_packet,
		output arrival_seconds, output arrival_fraction, input ready);
	modport sink (input valid, input packet_word, input start_of_packet,
		input arrival_seconds, input arrival_fraction, output ready);
endinterface

interface ntpod_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         leap_indicator;
	logic [2:0]         version_number;
	logic [2:0]         association_mode;
	logic [7:0]         stratum_level;
	logic [7:0]         poll_interval;
	logic signed [7:0]  clock_precision;
	logic signed [51:0] elapsed_us;
	logic signed [51:0] stall_us;
	logic signed [51:0] offset_us;
	logic signed [31:0] round_trip_us;
	logic [31:0]        set_seconds;
	logic [19:0]        set_microseconds;

	modport source (output valid, output leap_indicator, output version_number,
		output association_mode, output stratum_level, output poll_interval,
		output clock_precision, output elapsed_us, output stall_us, output offset_us,
		output round_trip_us, output set_seconds, output set_microseconds, input ready);
	modport sink (input valid, input leap_indicator, input version_number,
		input association_mode, input stratum_level, input poll_interval,
		input clock_precision, input elapsed_us, input stall_us, input offset_us,
		input round_trip_us, input set_seconds, input set_microseconds, output ready);
endinterface

interface ntpod_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] zone_offset_seconds;

	modport source (output valid, output zone_offset_seconds, input ready);
	modport sink (input valid, input zone_offset_seconds, output ready);
endinterface

/* design/ntpod_front.sv */
// Word collector: counts reply words, keeps the header and timestamps, emits jobs.
`timescale 1ns / 1ps
module ntpod_front (
	input  logic             clk,
	input  logic             arst_n,
	ntpod_in_if.sink         packet,
	ntpod_cfg_if.sink        cfg,
	input  logic             queue_full,
	output logic             push,
	output ntpod_pkg::job_t  job
);
	import ntpod_pkg::*;

	logic [3:0]         word_count_q;
	logic [31:0]        header_q;
	logic [31:0]        stamp_q [NUM_STAMPS];
	logic signed [16:0] zone_q;
	logic               accept;
	logic [3:0]         idx;
	logic               in_packet;

	assign cfg.ready    = 1'b1;
	assign packet.ready = !queue_full;
	assign accept       = packet.valid && packet.ready;
	assign idx          = packet.start_of_packet ? HEADER_WORD : word_count_q;
	assign in_packet    = idx < IDLE_COUNT;
	assign push         = accept && (idx == LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= IDLE_COUNT;
			zone_q       <= ZONE_RESET;
		end else begin
			if (cfg.valid) begin
				zone_q <= cfg.zone_offset_seconds;
			end
			if (accept && in_packet) begin
				word_count_q <= idx + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_packet) begin
			if (idx == HEADER_WORD) begin
				header_q <= packet.packet_word;
			end else if (idx >= FIRST_STAMP) begin
				stamp_q[3'(idx - FIRST_STAMP)] <= packet.packet_word;
			end
		end
	end

	// The last word is the transmit fraction, taken straight from the port.
	always_comb begin
		job.header    = header_q;
		job.originate = {stamp_q[0], stamp_q[1]};
		job.receive   = {stamp_q[2], stamp_q[3]};
		job.transmit  = {stamp_q[4], packet.packet_word};
		job.arrival   = {packet.arrival_seconds, packet.arrival_fraction};
		job.zone      = zone_q;
	end

endmodule

/* design/ntpod_queue.sv */
// Two-entry job queue between the word collector and the arithmetic pipeline.
`timescale 1ns / 1ps
module ntpod_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ntpod_pkg::job_t  push_job,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output ntpod_pkg::job_t  head
);
	import ntpod_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* design/ntpod_back.sv */
// Arithmetic pipeline: timestamp differences, microsecond scaling, result register.
`timescale 1ns / 1ps
module ntpod_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  ntpod_pkg::job_t  head,
	output logic             pop,
	ntpod_out_if.source      result
);
	import ntpod_pkg::*;

	logic en;
	logic v1_q, v2_q, v3_q, out_valid_q;

	// stage 1
	logic [31:0] hdr_s1;
	logic [63:0] del_s1, dst_s1, sk1_s1, sk2_s1;
	logic [31:0] set_s_s1;
	logic [19:0] set_u_s1;
	// stage 2
	logic [31:0] hdr_s2;
	logic signed [51:0] el_hp_s2, st_hp_s2;
	logic [19:0] el_lf_s2, st_lf_s2;
	logic [64:0] skew_s2;
	logic [31:0] set_s_s2;
	logic [19:0] set_u_s2;
	// stage 3
	logic [31:0] hdr_s3;
	logic signed [51:0] el_s3, st_s3, off_hp_s3;
	logic [19:0] off_lf_s3;
	logic [31:0] set_s_s3;
	logic [19:0] set_u_s3;
	// output register
	logic [31:0] hdr_q;
	logic signed [51:0] el_q, st_q, off_q;
	logic signed [31:0] rt_q;
	logic [31:0] set_s_q;
	logic [19:0] set_u_q;

	logic [31:0] round_sum;
	logic [15:0] round_q16;
	logic [31:0] scale_prod;
	logic [31:0] zone_ext;
	logic signed [52:0] el_hp_full, st_hp_full, off_hp_full;
	logic [51:0] el_lo_full, st_lo_full;
	logic [52:0] off_lo_full;
	logic signed [52:0] rt_full;

	// The whole pipeline moves together; it holds only while a result waits.
	assign en  = !out_valid_q || result.ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v1_q        <= !empty;
			v2_q        <= v1_q;
			v3_q        <= v2_q;
			out_valid_q <= v3_q;
		end
	end

	// Set-clock fraction: (f >> 12) - 759 * (((f >> 10) + 32768) >> 16).
	always_comb begin
		round_sum  = {10'd0, head.transmit[31:10]} + SETU_ROUND;
		round_q16  = round_sum[31:16];
		scale_prod = 32'(round_q16) * 32'(SETU_SCALE);
		zone_ext   = 32'(head.zone);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s1   <= head.header;
			del_s1   <= head.arrival - head.originate;
			dst_s1   <= head.transmit - head.receive;
			sk1_s1   <= head.receive - head.originate;
			sk2_s1   <= head.arrival - head.transmit;
			set_s_s1 <= head.transmit[63:32] - EPOCH_1900_TO_1970 + zone_ext;
			set_u_s1 <= 20'(({12'd0, head.transmit[31:12]}) - scale_prod);
		end
	end

	always_comb begin
		el_hp_full = $signed(del_s1[63:32]) * $signed({1'b0, USEC_PER_SEC});
		st_hp_full = $signed(dst_s1[63:32]) * $signed({1'b0, USEC_PER_SEC});
		el_lo_full = 52'(del_s1[31:0]) * 52'(USEC_PER_SEC);
		st_lo_full = 52'(dst_s1[31:0]) * 52'(USEC_PER_SEC);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s2   <= hdr_s1;
			el_hp_s2 <= el_hp_full[51:0];
			st_hp_s2 <= st_hp_full[51:0];
			el_lf_s2 <= el_lo_full[51:32];
			st_lf_s2 <= st_lo_full[51:32];
			// Exact 65-bit difference of the two signed skews.
			skew_s2  <= {sk1_s1[63], sk1_s1} - {sk2_s1[63], sk2_s1};
			set_s_s2 <= set_s_s1;
			set_u_s2 <= set_u_s1;
		end
	end

	// Halving the skew is absorbed into the scale: the top 32 bits are whole
	// double seconds and the low 33 bits a fraction in units of 2^-33.
	always_comb begin
		off_hp_full = $signed(skew_s2[64:33]) * $signed({1'b0, USEC_PER_SEC});
		off_lo_full = 53'(skew_s2[32:0]) * 53'(USEC_PER_SEC);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_s3    <= hdr_s2;
			el_s3     <= el_hp_s2 + $signed({32'd0, el_lf_s2});
			st_s3     <= st_hp_s2 + $signed({32'd0, st_lf_s2});
			off_hp_s3 <= off_hp_full[51:0];
			off_lf_s3 <= off_lo_full[52:33];
			set_s_s3  <= set_s_s2;
			set_u_s3  <= set_u_s2;
		end
	end

	assign rt_full = $signed({el_s3[51], el_s3}) - $signed({st_s3[51], st_s3});

	always_ff @(posedge clk) begin
		if (en) begin
			hdr_q   <= hdr_s3;
			el_q    <= el_s3;
			st_q    <= st_s3;
			off_q   <= off_hp_s3 + $signed({32'd0, off_lf_s3});
			set_s_q <= set_s_s3;
			set_u_q <= set_u_s3;
			if (rt_full > RT_MAX) begin
				rt_q <= RT_MAX[31:0];
			end else if (rt_full < RT_MIN) begin
				rt_q <= RT_MIN[31:0];
			end else begin
				rt_q <= rt_full[31:0];
			end
		end
	end

	assign result.valid            = out_valid_q;
	assign result.leap_indicator   = hdr_q[31:30];
	assign result.version_number   = hdr_q[29:27];
	assign result.association_mode = hdr_q[26:24];
	assign result.stratum_level    = hdr_q[23:16];
	assign result.poll_interval    = hdr_q[15:8];
	assign result.clock_precision  = $signed(hdr_q[7:0]);
	assign result.elapsed_us       = el_q;
	assign result.stall_us         = st_q;
	assign result.offset_us        = off_q;
	assign result.round_trip_us    = rt_q;
	assign result.set_seconds      = set_s_q;
	assign result.set_microseconds = set_u_q;

endmodule

/* design/ntp_reply_offset_delay_core.sv */
// Top level of the NTP reply offset and delay core.
`timescale 1ns / 1ps
// The core takes one reply word per clock on the packet channel, each with the
// local arrival timestamp, and needs no idle cycles between words or packets.
// A word with start_of_packet set begins a new reply (dropping any reply in
// progress); words after the twelfth, or before any start, are ignored. When
// word 11 is accepted, the reply passes through the queue and the four-register
// arithmetic pipeline (differences, products, sums, saturation) to one result
// transaction on the result channel. A two-entry queue sits between the word
// collector and the pipeline, so the packet channel keeps accepting while a
// result waits on a stalled result channel; it stops only once the queue holds
// two finished replies. The zone offset register is written through the cfg
// channel, which is always ready, and is sampled with each finished reply.
module ntp_reply_offset_delay_core (
	input  logic         clk,
	input  logic         arst_n,
	ntpod_in_if.sink     packet,
	ntpod_cfg_if.sink    cfg,
	ntpod_out_if.source  result
);
	import ntpod_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;

	// Front end: counts words, stores the header and timestamps.
	ntpod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.packet     (packet),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.job        (push_job)
	);

	// Decoupling queue of finished replies.
	ntpod_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head_job)
	);

	// Back end: fixed-point arithmetic and the result register.
	ntpod_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (queue_empty),
		.head   (head_job),
		.pop    (pop),
		.result (result)
	);

endmodule

/* dv/tb.sv */
// Self-checking testbench for the NTP reply offset and delay core.
`timescale 1ns / 1ps
// The testbench feeds reply words to the core over the packet channel and
// checks every result transaction against a predictor. The predictor frames
// the words exactly as the core must and keeps its own copy of the header,
// the six timestamp words and the zone offset. On word 11 it works out the
// expected reply with plain 64-bit integer arithmetic. The sender works in
// bursts with random gaps, and the result side stalls on a pattern of its own.
// The zone offset is rewritten only after the core has drained.
module tb;
	import ntpod_pkg::*;

	localparam int ITEM_TARGET   = 1650;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 16;
	localparam int LIMIT_CYCLES  = 500000;

	// Seconds between the 1900 era start and the Unix epoch.
	localparam logic [31:0] UNIX_EPOCH_OFFSET = 32'd2208988800;
	localparam longint RT_CEIL  = 64'sd2147483647;
	localparam longint RT_FLOOR = -64'sd2147483648;

	// One expected result transaction, field by field, at the port widths.
	typedef struct {
		logic [1:0]  leap;
		logic [2:0]  version;
		logic [2:0]  assoc;
		logic [7:0]  stratum;
		logic [7:0]  poll;
		logic [7:0]  precision;
		logic [51:0] elapsed;
		logic [51:0] stall;
		logic [51:0] offset;
		logic [31:0] round_trip;
		logic [31:0] set_sec;
		logic [19:0] set_usec;
	} reply_fix_t;

	logic clk = 1'b0;
	logic arst_n;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ntpod_in_if  packet_ch ();
	ntpod_cfg_if cfg_ch ();
	ntpod_out_if result_ch ();

	ntp_reply_offset_delay_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.packet (packet_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	// Predictor state: framing position, stored words and the zone register.
	logic [3:0]         word_pos      = IDLE_COUNT;
	logic [31:0]        header_seen   = '0;
	logic [31:0]        stamp_seen [NUM_STAMPS] = '{default: '0};
	logic signed [16:0] zone_setting  = ZONE_RESET;

	// Replies that the core owes us, oldest first.
	reply_fix_t expected_replies [$];

	int error_count    = 0;
	int words_absorbed = 0;
	int cycle_count    = 0;
	int burst_left     = 0;
	bit steady_sender  = 1'b0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A signed 32.32 difference in microseconds: the whole seconds are signed
	// and the fraction scales down with the floor taken.
	function automatic longint to_usec(logic [63:0] d);
		int     whole;
		longint part;
		whole = d[63:32];
		part  = longint'(({32'd0, d[31:0]} * 64'd1000000) >> 32);
		return longint'(whole) * 1000000 + part;
	endfunction

	function automatic reply_fix_t predict_reply(logic [31:0] arr_sec, logic [31:0] arr_frac);
		logic [63:0] org, rec, xmt, arr, skew_out, skew_back;
		logic [31:0] lo_out, lo_back, lo_diff, zone_ext, frac, usec;
		int          hi_out, hi_back;
		longint      el, st, hi, odd, half, frac_us, off, rt;
		reply_fix_t  r;
		org = {stamp_seen[0], stamp_seen[1]};
		rec = {stamp_seen[2], stamp_seen[3]};
		xmt = {stamp_seen[4], stamp_seen[5]};
		arr = {arr_sec, arr_frac};
		el  = to_usec(arr - org);
		st  = to_usec(xmt - rec);
		// The offset is the difference of the outbound and return skews, kept
		// exact at 65 bits with a true borrow out of the fraction, then halved.
		skew_out  = rec - org;
		skew_back = arr - xmt;
		hi_out  = skew_out[63:32];
		hi_back = skew_back[63:32];
		lo_out  = skew_out[31:0];
		lo_back = skew_back[31:0];
		hi = longint'(hi_out) - longint'(hi_back);
		if (lo_out < lo_back)
			hi = hi - 1;
		lo_diff = lo_out - lo_back;
		// An odd seconds part contributes half a second; the rest halves exactly.
		odd     = hi & 1;
		half    = (hi - odd) / 2;
		frac_us = longint'(({32'd0, lo_diff} * 64'd1000000) >> 33);
		off     = half * 1000000 + odd * 500000 + frac_us;
		rt = el - st;
		if (rt > RT_CEIL)
			rt = RT_CEIL;
		else if (rt < RT_FLOOR)
			rt = RT_FLOOR;
		zone_ext = {{15{zone_setting[16]}}, zone_setting};
		frac = xmt[31:0];
		// Shift-add approximation of fraction times one million over 2^32.
		usec = (frac >> 12) - 32'd759 * (((frac >> 10) + 32'd32768) >> 16);
		r.leap       = header_seen[31:30];
		r.version    = header_seen[29:27];
		r.assoc      = header_seen[26:24];
		r.stratum    = header_seen[23:16];
		r.poll       = header_seen[15:8];
		r.precision  = header_seen[7:0];
		r.elapsed    = el[51:0];
		r.stall      = st[51:0];
		r.offset     = off[51:0];
		r.round_trip = rt[31:0];
		r.set_sec    = xmt[63:32] - UNIX_EPOCH_OFFSET + zone_ext;
		r.set_usec   = usec[19:0];
		return r;
	endfunction

	// Frames one accepted word. Returns 1 when the word belongs to an open
	// packet, 0 when the core must ignore it.
	function automatic bit absorb_word(logic [31:0] w, logic sop, logic [31:0] arr_sec,
			logic [31:0] arr_frac);
		logic [3:0] idx;
		if (sop)
			word_pos = HEADER_WORD;
		if (word_pos >= IDLE_COUNT)
			return 1'b0;
		idx = word_pos;
		word_pos = idx + 4'd1;
		if (idx == HEADER_WORD)
			header_seen = w;
		else if (idx >= FIRST_STAMP)
			stamp_seen[idx - FIRST_STAMP] = w;
		if (idx == LAST_WORD)
			expected_replies.push_back(predict_reply(arr_sec, arr_frac));
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Sends one word and waits for its transaction. Within a burst valid stays
	// high, so the next call continues in the same time step without a drop.
	task automatic send_word(input logic [31:0] w, input logic sop,
			input logic [31:0] arr_sec, input logic [31:0] arr_frac);
		int gap;
		packet_ch.valid            <= 1'b1;
		packet_ch.packet_word      <= w;
		packet_ch.start_of_packet  <= sop;
		packet_ch.arrival_seconds  <= arr_sec;
		packet_ch.arrival_fraction <= arr_frac;
		@(posedge clk);
		while (!packet_ch.ready)
			@(posedge clk);
		if (absorb_word(w, sop, arr_sec, arr_frac))
			words_absorbed++;
		if (!steady_sender) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 15);
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
				packet_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Sends a full twelve-word reply. Only the arrival stamp that rides with
	// word 11 enters the arithmetic, so the earlier words carry random ones.
	task automatic send_reply(input logic [31:0] hdr, input logic [63:0] org,
			input logic [63:0] rec, input logic [63:0] xmt, input logic [63:0] arr);
		logic [31:0] words [12];
		words[0] = hdr;
		for (int i = 1; i < FIRST_STAMP; i++)
			words[i] = $urandom;
		words[6]  = org[63:32];
		words[7]  = org[31:0];
		words[8]  = rec[63:32];
		words[9]  = rec[31:0];
		words[10] = xmt[63:32];
		words[11] = xmt[31:0];
		for (int i = 0; i < 11; i++)
			send_word(words[i], i == 0, $urandom, $urandom);
		send_word(words[11], 1'b0, arr[63:32], arr[31:0]);
	endtask

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// A random signed step of the given number of bits, in 32.32 units.
	function automatic logic [63:0] jitter(int span);
		logic [63:0] r;
		r = {$urandom, $urandom};
		r = r << (64 - span);
		return $signed(r) >>> (64 - span);
	endfunction

	// Most replies are plausible exchanges with small skews, so the round trip
	// stays in range; a quarter use extreme stamp words to hit wrap and
	// saturation.
	task automatic send_random_reply();
		logic [63:0] org, rec, xmt, arr;
		if ($urandom_range(0, 3) == 0) begin
			org = {extreme_word(), extreme_word()};
			rec = {extreme_word(), extreme_word()};
			xmt = {extreme_word(), extreme_word()};
			arr = {extreme_word(), extreme_word()};
		end else begin
			org = {$urandom, $urandom};
			rec = org + jitter($urandom_range(8, 36));
			xmt = rec + jitter(30);
			arr = xmt + jitter($urandom_range(8, 36));
		end
		send_reply($urandom, org, rec, xmt, arr);
	endtask

	// Drops valid and waits until every expected reply has come back, then lets
	// anything still in flight settle.
	task automatic wait_idle();
		packet_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_zone(input int z);
		wait_idle();
		cfg_ch.valid               <= 1'b1;
		cfg_ch.zone_offset_seconds <= z[16:0];
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		zone_setting = z[16:0];
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (error_count < 100)
			$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	// Every result transaction is matched against the oldest pending reply.
	always @(posedge clk) begin : reply_checker
		reply_fix_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("result transaction with no reply pending");
			end else begin
				want = expected_replies.pop_front();
				check_field("leap_indicator", result_ch.leap_indicator, want.leap);
				check_field("version_number", result_ch.version_number, want.version);
				check_field("association_mode", result_ch.association_mode, want.assoc);
				check_field("stratum_level", result_ch.stratum_level, want.stratum);
				check_field("poll_interval", result_ch.poll_interval, want.poll);
				check_field("clock_precision", $unsigned(result_ch.clock_precision),
					want.precision);
				check_field("elapsed_us", $unsigned(result_ch.elapsed_us), want.elapsed);
				check_field("stall_us", $unsigned(result_ch.stall_us), want.stall);
				check_field("offset_us", $unsigned(result_ch.offset_us), want.offset);
				check_field("round_trip_us", $unsigned(result_ch.round_trip_us),
					want.round_trip);
				check_field("set_seconds", result_ch.set_seconds, want.set_sec);
				check_field("set_microseconds", result_ch.set_microseconds, want.set_usec);
			end
		end
	end

	// The result side switches between always ready, random stalls and rare long
	// stalls that let the core's reply queue fill.
	initial begin : result_sink
		int stall_left;
		int sink_mode;
		int sink_cycles;
		stall_left  = 0;
		sink_mode   = 0;
		sink_cycles = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			sink_cycles++;
			if (sink_cycles % 300 == 0)
				sink_mode = $urandom_range(0, 2);
			if (!arst_n) begin
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				case (sink_mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 3) != 0);
					default: begin
						result_ch.ready <= 1'b1;
						if ($urandom_range(0, 15) == 0)
							stall_left = $urandom_range(5, 40);
					end
				endcase
			end
		end
	end

	// A run that hangs on a handshake ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Framing corners at the reset zone offset: a word before any start is
	// ignored, a reply cut short by a new start mark is dropped, and a word
	// after the twelfth is ignored. The full reply uses all-ones and zero stamps.
	task automatic test_framing_directed();
		send_word(32'hffff_ffff, 1'b0, 32'hffff_ffff, 32'hffff_ffff);
		send_word(32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000);
		send_word($urandom, 1'b0, $urandom, $urandom);
		send_word($urandom, 1'b0, $urandom, $urandom);
		send_reply(32'hffff_ffff, '1, 64'h0, '1, 64'h0);
		send_word(32'h0000_0000, 1'b0, 32'h0000_0000, 32'h0000_0000);
	endtask

	// Both ends of the zone range and a few points between; each end gets a reply
	// with extreme stamps, each point between gets two random replies.
	task automatic test_zone_extremes();
		write_zone(-43200);
		send_reply(32'h0000_0000, 64'h0, '1, 64'h0, '1);
		write_zone(50400);
		send_reply(32'h1c02_03e9, 64'h0, 64'h8000_0000_0000_0000,
			64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
		write_zone(0);
		send_random_reply();
		send_random_reply();
		write_zone(-1);
		send_random_reply();
		send_random_reply();
	endtask

	// The sender holds off after each reply until the core has answered.
	task automatic test_drain_between_replies();
		for (int i = 0; i < 6; i++) begin
			send_random_reply();
			wait_idle();
		end
	endtask

	// Replies back to back with no idle cycles, against whatever the result
	// side is doing, so the two-entry queue gets to push back on the sender.
	task automatic test_back_to_back_replies();
		steady_sender = 1'b1;
		for (int i = 0; i < 8; i++)
			send_random_reply();
		steady_sender = 1'b0;
		wait_idle();
	endtask

	// Mostly well-formed replies, mixed with truncated replies, stray words
	// after a reply and random start marks. Stray words without a start mark
	// can complete a truncated reply, which is also predicted.
	task automatic test_random_traffic();
		int kind;
		int n;
		while (words_absorbed < ITEM_TARGET) begin
			if ($urandom_range(0, 199) == 0)
				write_zone(int'($urandom_range(0, 93600)) - 43200);
			if ($urandom_range(0, 99) == 0)
				wait_idle();
			if ($urandom_range(0, 49) == 0)
				steady_sender = !steady_sender;
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_random_reply();
			end else if (kind < 80) begin
				n = $urandom_range(1, 11);
				send_word($urandom, 1'b1, $urandom, $urandom);
				for (int i = 1; i < n; i++)
					send_word($urandom, 1'b0, $urandom, $urandom);
			end else if (kind < 90) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					send_word($urandom, 1'b0, $urandom, $urandom);
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_word($urandom, $urandom_range(0, 3) == 0, $urandom, $urandom);
			end
		end
		steady_sender = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		packet_ch.valid            = 1'b0;
		packet_ch.packet_word      = '0;
		packet_ch.start_of_packet  = 1'b0;
		packet_ch.arrival_seconds  = '0;
		packet_ch.arrival_fraction = '0;
		cfg_ch.valid               = 1'b0;
		cfg_ch.zone_offset_seconds = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_framing_directed();
		test_zone_extremes();
		test_drain_between_replies();
		test_back_to_back_replies();
		test_random_traffic();

		// Let the last replies come out and watch a little longer for extras.
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
